// File: hw/rtl/belady_optimal_cache_replacement_core_defines.svh
// Assertion helpers for the Belady replacement core.
`ifndef BELADY_OPTIMAL_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define BELADY_OPTIMAL_CACHE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BOCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bocr check failed");
// Next-cycle implication, checked out of reset.
`define BOCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bocr check failed");
`else
`define BOCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BOCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/bocr_pkg.sv
package bocr_pkg;

    localparam int ADDR_W       = 48;
    localparam int IDX_W        = 32;
    localparam int TIME_W       = 33;
    localparam int WAY_OUT_W    = 4;
    localparam int OFF_W        = 4;
    localparam int MOD_DIGIT_W  = 4;

    localparam logic [OFF_W-1:0]  OFFSET_RESET = 4'd6;
    localparam logic [TIME_W-1:0] FAR_TIME     = {1'b1, {(TIME_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_LOOK,
        S_REDUCE,
        S_WRITE
    } t_state;

endpackage

// File: hw/rtl/bocr_ram.sv
module bocr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bocr_set_mod.sv
module bocr_set_mod #(
    parameter int NUM_SETS = 256,
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bocr_pkg::ADDR_W-1:0] i_value,
    output logic                      o_done,
    output logic [SET_W-1:0]          o_rem
);

    localparam bit IS_POW2 = (NUM_SETS > 1) && ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam int STEPS   = bocr_pkg::ADDR_W / bocr_pkg::MOD_DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS);

    logic r_done;
    logic [SET_W-1:0] r_rem;

    assign o_done = r_done;
    assign o_rem  = r_rem;

    if (IS_POW2) begin : g_pow2
        // take the low bits directly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= i_value[SET_W-1:0];
            end
        end
    end else begin : g_serial
        localparam logic [SET_W:0] NSETS = (SET_W+1)'(NUM_SETS);

        logic                        r_busy;
        logic [CNT_W-1:0]            r_cnt;
        logic [bocr_pkg::ADDR_W-1:0] r_val;
        logic [SET_W-1:0]            n_rem;

        // fold in one digit, MSB first, one compare and subtract per bit
        always_comb begin
            logic [SET_W:0]   t;
            logic [SET_W-1:0] v;
            v = r_rem;
            for (int k = 0; k < bocr_pkg::MOD_DIGIT_W; k++) begin
                t = {v, r_val[bocr_pkg::ADDR_W-1-k]};
                if (t >= NSETS) begin
                    t = t - NSETS;
                end
                v = t[SET_W-1:0];
            end
            n_rem = v;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_val <= i_value;
                r_rem <= '0;
            end else if (r_busy) begin
                r_val <= r_val << bocr_pkg::MOD_DIGIT_W;
                r_rem <= n_rem;
            end
        end
    end

endmodule

// File: hw/rtl/belady_optimal_cache_replacement_core.sv
// Flow: an input transfer passes through S_MOD, which finds the set index and then issues
// the set-row read (by a serial remainder if NUM_SETS is not a power of two), S_LOOK for
// the lookup, one S_REDUCE step per compare-tree level, then S_WRITE writes back and
// sets result valid. Only one access is in flight; a stalled result holds the next one.
// Reset: synchronous, active low; a clearing pass zeroes every set row and
// blocks input transfers until it ends. Line offset resets to 6.
`include "belady_optimal_cache_replacement_core_defines.svh"

module belady_optimal_cache_replacement_core #(
    parameter int NUM_SETS         = 256,
    parameter int NUM_WAYS         = 16,
    parameter int TRACE_INDEX_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // access channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bocr_pkg::ADDR_W-1:0]       i_address,
    input  logic [bocr_pkg::IDX_W-1:0]        i_next_use_index,
    input  logic                              i_never_again,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [bocr_pkg::WAY_OUT_W-1:0]    o_way_used,
    output logic                              o_evicted_valid,
    output logic [bocr_pkg::ADDR_W-1:0]       o_evicted_line,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bocr_pkg::OFF_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = bocr_pkg::ADDR_W;
    localparam int TIME_W = bocr_pkg::TIME_W;
    localparam int LVL    = $clog2(NUM_WAYS);
    localparam int WP2    = 1 << LVL;
    localparam int WAY_W  = (LVL > 0) ? LVL : 1;
    localparam int LVL_W  = ($clog2(LVL + 1) > 0) ? $clog2(LVL + 1) : 1;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ENT_W  = 1 + ADDR_W + TIME_W;
    localparam int ROW_W  = NUM_WAYS * ENT_W;
    localparam int TB     = (TRACE_INDEX_BITS < 32) ? TRACE_INDEX_BITS : 32;
    localparam logic [bocr_pkg::IDX_W-1:0] IDX_MASK =
        (TB >= 32) ? '1 : bocr_pkg::IDX_W'((64'd1 << TB) - 64'd1);

    bocr_pkg::t_state r_state, n_state;

    logic [bocr_pkg::OFF_W-1:0] r_offset;
    logic [SET_W-1:0]           r_clr_idx;
    logic [SET_W-1:0]           r_set;
    logic [ADDR_W-1:0]          r_line;
    logic [TIME_W-1:0]          r_time;
    logic [LVL_W-1:0]           r_lvl;

    logic                       r_hit;
    logic [WAY_W-1:0]           r_hit_way;
    logic                       r_empty;
    logic [WAY_W-1:0]           r_empty_way;
    logic [TIME_W-1:0]          r_rt [WP2];
    logic [WAY_W-1:0]           r_rw [WP2];

    logic                       r_out_valid;
    logic                       r_o_hit;
    logic [WAY_W-1:0]           r_o_way;
    logic                       r_o_ev_valid;
    logic [ADDR_W-1:0]          r_o_ev_line;

    logic                       in_xfer;
    logic                       out_free;
    logic [ADDR_W-1:0]          acc_line;
    logic [TIME_W-1:0]          acc_time;

    logic                       mod_done;
    logic [SET_W-1:0]           mod_rem;

    logic                       ram_we;
    logic [SET_W-1:0]           ram_waddr;
    logic [ROW_W-1:0]           ram_wdata;
    logic                       ram_re;
    logic [ROW_W-1:0]           ram_rdata;

    logic                       lk_hit;
    logic [WAY_W-1:0]           lk_hit_way;
    logic                       lk_empty;
    logic [WAY_W-1:0]           lk_empty_way;

    logic [WAY_W-1:0]           sel_way;
    logic [ROW_W-1:0]           new_row;
    logic [ADDR_W-1:0]          victim_tag;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == bocr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // line address and next-use time of the incoming access
    assign acc_line = i_address >> r_offset;
    assign acc_time = i_never_again ? bocr_pkg::FAR_TIME
                                    : {1'b0, i_next_use_index & IDX_MASK};

    bocr_set_mod #(
        .NUM_SETS (NUM_SETS)
    ) u_set_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_value (acc_line),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    bocr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (mod_rem),
        .o_rdata (ram_rdata)
    );

    // find the lowest matching valid way and the lowest empty way
    always_comb begin
        logic [ENT_W-1:0] ent;
        lk_hit       = 1'b0;
        lk_hit_way   = '0;
        lk_empty     = 1'b0;
        lk_empty_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            ent = ram_rdata[w*ENT_W +: ENT_W];
            if (ent[ENT_W-1]) begin
                if (!lk_hit && (ent[TIME_W +: ADDR_W] == r_line)) begin
                    lk_hit     = 1'b1;
                    lk_hit_way = WAY_W'(w);
                end
            end else if (!lk_empty) begin
                lk_empty     = 1'b1;
                lk_empty_way = WAY_W'(w);
            end
        end
    end

    // pick the way to update and build the written-back row
    always_comb begin
        logic [ENT_W-1:0] ent;
        if (r_hit) begin
            sel_way = r_hit_way;
        end else if (r_empty) begin
            sel_way = r_empty_way;
        end else begin
            sel_way = r_rw[0];
        end
        new_row    = ram_rdata;
        victim_tag = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            ent = ram_rdata[w*ENT_W +: ENT_W];
            if (WAY_W'(w) == sel_way) begin
                victim_tag = ent[TIME_W +: ADDR_W];
                if (r_hit) begin
                    ent[TIME_W-1:0] = r_time;
                end else begin
                    ent = {1'b1, r_line, r_time};
                end
                new_row[w*ENT_W +: ENT_W] = ent;
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bocr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = new_row;
        ram_re    = 1'b0;
        case (r_state)
            bocr_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                    n_state = bocr_pkg::S_IDLE;
                end
            end
            bocr_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = bocr_pkg::S_MOD;
                end
            end
            bocr_pkg::S_MOD: begin
                if (mod_done) begin
                    ram_re  = 1'b1;
                    n_state = bocr_pkg::S_LOOK;
                end
            end
            bocr_pkg::S_LOOK: begin
                n_state = (LVL == 0) ? bocr_pkg::S_WRITE : bocr_pkg::S_REDUCE;
            end
            bocr_pkg::S_REDUCE: begin
                if (r_lvl == LVL_W'(LVL - 1)) begin
                    n_state = bocr_pkg::S_WRITE;
                end
            end
            bocr_pkg::S_WRITE: begin
                if (out_free) begin
                    ram_we  = 1'b1;
                    n_state = bocr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bocr_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= bocr_pkg::OFFSET_RESET;
            r_clr_idx   <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_offset <= i_cfg_data;
            end
            if (r_state == bocr_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == bocr_pkg::S_LOOK) begin
                r_lvl <= '0;
            end else if (r_state == bocr_pkg::S_REDUCE) begin
                r_lvl <= r_lvl + 1'b1;
            end
            if (r_state == bocr_pkg::S_WRITE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // access payload, lookup results and the compare tree
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_line <= acc_line;
            r_time <= acc_time;
        end
        if (r_state == bocr_pkg::S_MOD && mod_done) begin
            r_set <= mod_rem;
        end
        if (r_state == bocr_pkg::S_LOOK) begin
            r_hit       <= lk_hit;
            r_hit_way   <= lk_hit_way;
            r_empty     <= lk_empty;
            r_empty_way <= lk_empty_way;
            for (int i = 0; i < WP2; i++) begin
                r_rw[i] <= WAY_W'(i);
                if (i < NUM_WAYS) begin
                    r_rt[i] <= ram_rdata[i*ENT_W +: TIME_W];
                end else begin
                    r_rt[i] <= '0;
                end
            end
        end else if (r_state == bocr_pkg::S_REDUCE) begin
            // one tree level: later way wins only if strictly further
            for (int i = 0; i < WP2 / 2; i++) begin
                if (r_rt[2*i+1] > r_rt[2*i]) begin
                    r_rt[i] <= r_rt[2*i+1];
                    r_rw[i] <= r_rw[2*i+1];
                end else begin
                    r_rt[i] <= r_rt[2*i];
                    r_rw[i] <= r_rw[2*i];
                end
            end
        end
        if (r_state == bocr_pkg::S_WRITE && out_free) begin
            r_o_hit      <= r_hit;
            r_o_way      <= sel_way;
            r_o_ev_valid <= !r_hit && !r_empty;
            r_o_ev_line  <= (!r_hit && !r_empty) ? victim_tag : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_way_used      = bocr_pkg::WAY_OUT_W'(r_o_way);
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_line  = r_o_ev_line;

    // checks
    `BOCR_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, o_out_valid && o_hit, !o_evicted_valid && (o_evicted_line == '0))
    `BOCR_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, ram_re, !ram_we)
    `BOCR_ASSERT_NXT(a_wb_result, i_clk, i_rst_n, (r_state == bocr_pkg::S_WRITE) && out_free, o_out_valid && (r_state == bocr_pkg::S_IDLE))

endmodule

// File: tb/sv/belady_cache_checker.sv
module belady_cache_checker #(
    parameter int NUM_SETS         = 256,
    parameter int NUM_WAYS         = 16,
    parameter int TRACE_INDEX_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // access channel
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [bocr_pkg::ADDR_W-1:0]      i_address,
    input  logic [bocr_pkg::IDX_W-1:0]       i_next_use_index,
    input  logic                             i_never_again,
    // result channel
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_hit,
    input  logic [bocr_pkg::WAY_OUT_W-1:0]   i_way_used,
    input  logic                             i_evicted_valid,
    input  logic [bocr_pkg::ADDR_W-1:0]      i_evicted_line,
    // configuration channel
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bocr_pkg::OFF_W-1:0]       i_cfg_data,
    // status
    output int                               o_pending,
    output int                               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W    = bocr_pkg::ADDR_W;
    localparam int IDX_W     = bocr_pkg::IDX_W;
    localparam int TIME_W    = bocr_pkg::TIME_W;
    localparam int WAY_OUT_W = bocr_pkg::WAY_OUT_W;
    localparam int OFF_W     = bocr_pkg::OFF_W;

    localparam int ENTRIES = NUM_SETS * NUM_WAYS;
    localparam logic [IDX_W-1:0] TIME_MASK =
        (TRACE_INDEX_BITS < IDX_W) ? ((32'd1 << TRACE_INDEX_BITS) - 32'd1) : '1;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted_valid;
        logic [ADDR_W-1:0]    evicted_line;
    } t_lookup_result;

    // shadow tag store
    logic                way_valid    [ENTRIES];
    logic [ADDR_W-1:0]   way_tag      [ENTRIES];
    logic [TIME_W-1:0]   way_next_use [ENTRIES];
    logic [OFF_W-1:0]    line_shift;

    t_lookup_result      expected_results [$];
    t_lookup_result      got;
    t_lookup_result      want;
    int                  fail_count;

    // Look up one access, apply furthest-next-use replacement, return the outcome
    function automatic t_lookup_result opt_access(input logic [ADDR_W-1:0] addr,
                                                  input logic [IDX_W-1:0]  idx,
                                                  input logic              never);
        logic [ADDR_W-1:0] line;
        logic [TIME_W-1:0] use_time;
        logic [TIME_W-1:0] furthest;
        int                base;
        int                hit_way;
        int                empty_way;
        int                victim;
        t_lookup_result    res;

        use_time  = never ? bocr_pkg::FAR_TIME : {1'b0, idx & TIME_MASK};
        line      = addr >> line_shift;
        base      = int'(line % NUM_SETS) * NUM_WAYS;
        hit_way   = -1;
        empty_way = -1;
        res       = '0;

        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_valid[base + w]) begin
                if (hit_way < 0 && way_tag[base + w] == line)
                    hit_way = w;
            end else if (empty_way < 0) begin
                empty_way = w;
            end
        end

        if (hit_way >= 0) begin
            way_next_use[base + hit_way] = use_time;
            res.hit = 1'b1;
            res.way = WAY_OUT_W'(hit_way);
        end else begin
            if (empty_way >= 0) begin
                victim = empty_way;
            end else begin
                // strict compare keeps the lowest way on a tie
                victim   = 0;
                furthest = way_next_use[base];
                for (int w = 1; w < NUM_WAYS; w++) begin
                    if (way_next_use[base + w] > furthest) begin
                        furthest = way_next_use[base + w];
                        victim   = w;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_line  = way_tag[base + victim];
            end
            way_valid[base + victim]    = 1'b1;
            way_tag[base + victim]      = line;
            way_next_use[base + victim] = use_time;
            res.way = WAY_OUT_W'(victim);
        end
        return res;
    endfunction

    // Compare result transfers first, then predict the access transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++)
                way_valid[e] = 1'b0;
            line_shift = bocr_pkg::OFFSET_RESET;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_hit, i_way_used, i_evicted_valid, i_evicted_line};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: hit=%0b way=%0d ev=%0b line=%h",
                                 $realtime, got.hit, got.way, got.evicted_valid,
                                 got.evicted_line);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $write("%0t: mismatch: expected hit=%0b way=%0d ev=%0b line=%h,",
                                   $realtime, want.hit, want.way, want.evicted_valid,
                                   want.evicted_line);
                            $display(" actual hit=%0b way=%0d ev=%0b line=%h",
                                     got.hit, got.way, got.evicted_valid, got.evicted_line);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(opt_access(i_address, i_next_use_index,
                                                      i_never_again));
            if (i_cfg_valid && i_cfg_ready)
                line_shift = i_cfg_data;
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/sv/tb_belady_optimal_cache_replacement_core.sv
module tb_belady_optimal_cache_replacement_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W          = bocr_pkg::ADDR_W;
    localparam int IDX_W           = bocr_pkg::IDX_W;
    localparam int WAY_OUT_W       = bocr_pkg::WAY_OUT_W;
    localparam int OFF_W           = bocr_pkg::OFF_W;

    localparam int CLK_PERIOD      = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int POOL_SIZE       = 24;
    localparam int SETTLE_CYCLES   = 24;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [ADDR_W-1:0]     i_address        = '0;
    logic [IDX_W-1:0]      i_next_use_index = '0;
    logic                  i_never_again    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic                  o_hit;
    logic [WAY_OUT_W-1:0]  o_way_used;
    logic                  o_evicted_valid;
    logic [ADDR_W-1:0]     o_evicted_line;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [OFF_W-1:0]      i_cfg_data       = '0;

    int                    pending;
    int                    fail_count;
    int                    burst_left       = 0;
    int                    idle_cycles      = 0;
    logic [15:0]           ready_pattern    = 16'hFFFF;
    int                    pattern_pos      = 0;
    logic [ADDR_W-1:0]     line_pool [POOL_SIZE];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    belady_optimal_cache_replacement_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_address        (i_address),
        .i_next_use_index (i_next_use_index),
        .i_never_again    (i_never_again),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_way_used       (o_way_used),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_line   (o_evicted_line),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    belady_cache_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_address        (i_address),
        .i_next_use_index (i_next_use_index),
        .i_never_again    (i_never_again),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_hit            (o_hit),
        .i_way_used       (o_way_used),
        .i_evicted_valid  (o_evicted_valid),
        .i_evicted_line   (o_evicted_line),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // Stall the result channel on a 16-bit ready pattern, re-drawn each window
    always @(posedge i_clk) begin
        if (pattern_pos == 15) begin
            pattern_pos <= 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= '1;
                3:       ready_pattern <= 16'($urandom & $urandom & $urandom);
                default: ready_pattern <= 16'($urandom);
            endcase
        end else begin
            pattern_pos <= pattern_pos + 1;
        end
        i_out_ready <= ready_pattern[pattern_pos];
    end

    // End the run if no channel moves a transfer for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one access, hold until its transfer, then maybe drop into a gap
    task automatic send_access(input logic [ADDR_W-1:0] addr,
                               input logic [IDX_W-1:0]  idx,
                               input logic              never);
        i_in_valid       <= 1'b1;
        i_address        <= addr;
        i_next_use_index <= idx;
        i_never_again    <= never;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge i_clk);
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (12)
            @(posedge i_clk);
    endtask

    initial begin
        logic [OFF_W-1:0]  shifts [NUM_PHASES];
        logic [OFF_W-1:0]  shift;
        logic [ADDR_W-1:0] line;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        hot_set;
        logic [7:0]        cold_set;
        int unsigned       pick;

        shifts    = '{4'd0, 4'd15, 4'd12, 4'd13, 4'd6, 4'd9, 4'd3};
        shifts[5] = OFF_W'($urandom_range(1, 11));

        repeat (3)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, hit with never-again, fills and evictions in set 3
        send_access('1, '1, 1'b0);
        send_access('0, '0, 1'b0);
        send_access(48'h3F, 32'h1234, 1'b1);
        for (int k = 1; k <= 16; k++)
            send_access(48'(((k << 8) | 3) << 6), 32'd40, (k == 5 || k == 9));
        // evict the first never-again way, then tie two never-again ways
        send_access(48'(((17 << 8) | 3) << 6), 32'd10, 1'b0);
        send_access(48'(((2 << 8) | 3) << 6) | 48'h2A, 32'd0, 1'b1);
        send_access(48'(((18 << 8) | 3) << 6), 32'd7, 1'b0);
        send_access(48'(((5 << 8) | 3) << 6), 32'd3, 1'b0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            shift = shifts[p];

            // Write the line offset while the block is idle
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= shift;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            i_cfg_valid <= 1'b0;

            // Refill most of the pool; crowd one set so lines get evicted
            hot_set  = 8'($urandom);
            cold_set = p[0] ? 8'hFF : 8'h00;
            low_mask = (48'd1 << shift) - 48'd1;
            for (int j = (p == 0) ? 0 : POOL_SIZE / 4; j < POOL_SIZE; j++) begin
                line      = 48'({$urandom, $urandom}) >> shift;
                line[7:0] = ($urandom_range(0, 3) == 0) ? cold_set : hot_set;
                line_pool[j] = line << shift;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    addr = line_pool[$urandom_range(0, POOL_SIZE - 1)] |
                           (48'($urandom) & low_mask);
                else
                    addr = 48'({$urandom, $urandom});
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    idx = IDX_W'($urandom_range(0, 15));
                else if (pick < 30)
                    idx = '1;
                else
                    idx = $urandom;
                send_access(addr, idx, ($urandom_range(0, 9) == 0));
                if (p == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
